/* src/pbwd_pkg.sv */
package pbwd_pkg;

  typedef enum logic [1:0] {
    KIND_SCALAR  = 2'd0,
    KIND_LENGTH  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } pbwd_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_TAG_OVF    = 3'd1,
    ERR_VARINT_OVF = 3'd2,
    ERR_BAD_WIRE   = 3'd3,
    ERR_TRUNCATED  = 3'd4
  } pbwd_err_e;

  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LEN     = 3'd2;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;

  localparam logic [63:0] TOP7_MASK = 64'hfe00_0000_0000_0000;

  typedef struct packed {
    pbwd_kind_e         kind;
    logic [28:0]        field_number;
    logic [2:0]         wire_kind;
    logic [63:0]        raw_value;
    logic signed [63:0] signed_value;
    logic [7:0]         payload_byte;
    logic               last_byte;
    pbwd_err_e          error_code;
  } pbwd_result_t;

endpackage

/* src/pbwd_core.sv */
module pbwd_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  stream_end_i,
  output logic                  res_valid_o,
  output pbwd_pkg::pbwd_result_t res_o
);
  import pbwd_pkg::*;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_FIXED   = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_HALT    = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic [6:0]  shift_q, shift_d;
  logic [28:0] field_q, field_d;
  logic [2:0]  wire_q, wire_d;
  logic [3:0]  fixed_left_q, fixed_left_d;
  logic [63:0] pay_left_q, pay_left_d;

  logic        ovf;
  logic [63:0] acc_abs, acc_fix;
  logic [6:0]  shift_abs, shift_fix;
  logic [3:0]  fixed_left_n;
  logic [63:0] pay_left_n;

  always_comb begin
    ovf = |(acc_q & TOP7_MASK);
    if (!shift_q[6]) begin
      acc_abs   = acc_q | ({57'd0, data_byte_i[6:0]} << shift_q[5:0]);
      shift_abs = 7'(shift_q + 7'd7);
      acc_fix   = acc_q | ({56'd0, data_byte_i} << shift_q[5:0]);
      shift_fix = 7'(shift_q + 7'd8);
    end else begin
      acc_abs   = acc_q;
      shift_abs = shift_q;
      acc_fix   = acc_q;
      shift_fix = shift_q;
    end
    fixed_left_n = (fixed_left_q != 4'd0) ? 4'(fixed_left_q - 4'd1) : fixed_left_q;
    pay_left_n   = (pay_left_q != 64'd0) ? 64'(pay_left_q - 64'd1) : pay_left_q;
  end

  always_comb begin
    phase_d      = phase_q;
    acc_d        = acc_q;
    shift_d      = shift_q;
    field_d      = field_q;
    wire_d       = wire_q;
    fixed_left_d = fixed_left_q;
    pay_left_d   = pay_left_q;
    res_valid_o  = 1'b0;
    res_o              = '0;
    res_o.field_number = field_q;
    res_o.wire_kind    = wire_q;

    if (stream_end_i) begin
      if (!(phase_q == PH_HALT || (phase_q == PH_TAG && shift_q == 7'd0))) begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_ERROR;
        res_o.error_code = ERR_TRUNCATED;
        if (phase_q == PH_TAG) begin
          res_o.field_number = '0;
          res_o.wire_kind    = '0;
        end
      end
      phase_d      = PH_TAG;
      acc_d        = '0;
      shift_d      = '0;
      field_d      = '0;
      wire_d       = '0;
      fixed_left_d = '0;
      pay_left_d   = '0;
    end else begin
      case (phase_q)
        PH_TAG: begin
          field_d            = '0;
          wire_d             = '0;
          res_o.field_number = '0;
          res_o.wire_kind    = '0;
          if (ovf) begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_VARINT_OVF;
            acc_d            = '0;
            shift_d          = '0;
            phase_d          = PH_HALT;
          end else if (data_byte_i[7]) begin
            acc_d   = acc_abs;
            shift_d = shift_abs;
          end else begin
            acc_d   = '0;
            shift_d = '0;
            if (|acc_abs[63:32]) begin
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_ERROR;
              res_o.error_code = ERR_TAG_OVF;
              phase_d          = PH_HALT;
            end else begin
              field_d = acc_abs[31:3];
              wire_d  = acc_abs[2:0];
              case (acc_abs[2:0])
                WIRE_VARINT: phase_d = PH_VARINT;
                WIRE_FIXED64: begin
                  fixed_left_d = 4'd8;
                  phase_d      = PH_FIXED;
                end
                WIRE_FIXED32: begin
                  fixed_left_d = 4'd4;
                  phase_d      = PH_FIXED;
                end
                WIRE_LEN: phase_d = PH_LENGTH;
                default: begin
                  res_valid_o        = 1'b1;
                  res_o.kind         = KIND_ERROR;
                  res_o.error_code   = ERR_BAD_WIRE;
                  res_o.field_number = acc_abs[31:3];
                  res_o.wire_kind    = acc_abs[2:0];
                  phase_d            = PH_HALT;
                end
              endcase
            end
          end
        end
        PH_VARINT, PH_LENGTH: begin
          if (ovf) begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_VARINT_OVF;
            acc_d            = '0;
            shift_d          = '0;
            phase_d          = PH_HALT;
          end else if (data_byte_i[7]) begin
            acc_d   = acc_abs;
            shift_d = shift_abs;
          end else begin
            res_valid_o     = 1'b1;
            res_o.raw_value = acc_abs;
            acc_d           = '0;
            shift_d         = '0;
            if (phase_q == PH_VARINT) begin
              res_o.kind         = KIND_SCALAR;
              res_o.signed_value = (acc_abs >> 1) ^ {64{acc_abs[0]}};
              phase_d            = PH_TAG;
            end else begin
              res_o.kind = KIND_LENGTH;
              pay_left_d = acc_abs;
              phase_d    = (acc_abs == 64'd0) ? PH_TAG : PH_PAYLOAD;
            end
          end
        end
        PH_FIXED: begin
          acc_d        = acc_fix;
          shift_d      = shift_fix;
          fixed_left_d = fixed_left_n;
          if (fixed_left_n == 4'd0) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_SCALAR;
            if (wire_q == WIRE_FIXED32) begin
              res_o.raw_value    = {32'd0, acc_fix[31:0]};
              res_o.signed_value = {{32{acc_fix[31]}}, acc_fix[31:0]};
            end else begin
              res_o.raw_value    = acc_fix;
              res_o.signed_value = acc_fix;
            end
            acc_d   = '0;
            shift_d = '0;
            phase_d = PH_TAG;
          end
        end
        PH_PAYLOAD: begin
          pay_left_d         = pay_left_n;
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_PAYLOAD;
          res_o.payload_byte = data_byte_i;
          res_o.last_byte    = (pay_left_n == 64'd0);
          if (pay_left_n == 64'd0) begin
            phase_d = PH_TAG;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TAG;
      acc_q        <= '0;
      shift_q      <= '0;
      field_q      <= '0;
      wire_q       <= '0;
      fixed_left_q <= '0;
      pay_left_q   <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      acc_q        <= acc_d;
      shift_q      <= shift_d;
      field_q      <= field_d;
      wire_q       <= wire_d;
      fixed_left_q <= fixed_left_d;
      pay_left_q   <= pay_left_d;
    end
  end

endmodule

/* src/pbwd_out_buf.sv */
module pbwd_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pbwd_pkg::pbwd_result_t res_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output pbwd_pkg::pbwd_result_t res_o,
  output logic                  full_o
);
  import pbwd_pkg::*;

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  pbwd_result_t out_q, out_d;
  pbwd_result_t skid_q, skid_d;
  logic         pop;

  assign pop         = out_valid_q & out_ready_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign full_o      = skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

/* src/protobuf_wire_field_decoder.sv */
// Protobuf wire-format field decoder. Takes one stream byte per beat and
// sustains one byte per cycle while in_ready_o is high. Each result is
// registered after the per-byte decode logic, in the output result
// register or, while the sink stalls, in the one skid entry, so
// in_ready_o only drops after two results are left waiting.
module protobuf_wire_field_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               stream_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [28:0]        field_number_o,
  output logic [2:0]         wire_kind_o,
  output logic [63:0]        raw_value_o,
  output logic signed [63:0] signed_value_o,
  output logic [7:0]         payload_byte_o,
  output logic               last_byte_o,
  output logic [2:0]         error_code_o
);
  import pbwd_pkg::*;

  logic         step;
  logic         res_valid;
  logic         buf_full;
  pbwd_result_t res;
  pbwd_result_t out_res;

  assign in_ready_o = ~buf_full;
  assign step       = in_valid_i & in_ready_o;

  pbwd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (data_byte_i),
    .stream_end_i (stream_end_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  pbwd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step & res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res),
    .full_o      (buf_full)
  );

  assign kind_o         = out_res.kind;
  assign field_number_o = out_res.field_number;
  assign wire_kind_o    = out_res.wire_kind;
  assign raw_value_o    = out_res.raw_value;
  assign signed_value_o = out_res.signed_value;
  assign payload_byte_o = out_res.payload_byte;
  assign last_byte_o    = out_res.last_byte;
  assign error_code_o   = out_res.error_code;

endmodule

/* src/pbwd_checker.sv */
module pbwd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         kind_o,
  input logic [2:0]         wire_kind_o,
  input logic [63:0]        raw_value_o,
  input logic signed [63:0] signed_value_o,
  input logic [7:0]         payload_byte_o,
  input logic               last_byte_o,
  input logic [2:0]         error_code_o
);
  import pbwd_pkg::*;

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(raw_value_o) && $stable(payload_byte_o) && $stable(error_code_o))
    else $error("output beat changed while stalled");

  // input only stalls while a result is held back by the sink
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && $past(out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERROR |-> error_code_o != ERR_NONE
      && raw_value_o == 64'd0 && signed_value_o == 64'sd0
      && payload_byte_o == 8'd0 && last_byte_o == 1'b0)
    else $error("error beat carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SCALAR && wire_kind_o == WIRE_VARINT
      |-> signed_value_o == ((raw_value_o >> 1) ^ {64{raw_value_o[0]}}))
    else $error("varint zigzag view mismatch");

endmodule

bind protobuf_wire_field_decoder pbwd_checker u_pbwd_checker (.*);

/* tb/tb_protobuf_wire_field_decoder.sv */
`timescale 1ns / 1ps

module tb_protobuf_wire_field_decoder;
  import pbwd_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       eos;
  } stream_beat_t;

  typedef enum logic [2:0] {
    DEC_TAG,
    DEC_VARINT,
    DEC_FIXED,
    DEC_LENGTH,
    DEC_PAYLOAD,
    DEC_HALT
  } dec_phase_e;

  typedef enum int {
    VI_MORE,
    VI_DONE,
    VI_OVF
  } varint_step_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i = 8'd0;
  logic               stream_end_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         kind_o;
  logic [28:0]        field_number_o;
  logic [2:0]         wire_kind_o;
  logic [63:0]        raw_value_o;
  logic signed [63:0] signed_value_o;
  logic [7:0]         payload_byte_o;
  logic               last_byte_o;
  logic [2:0]         error_code_o;

  protobuf_wire_field_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .stream_end_i   (stream_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .field_number_o (field_number_o),
    .wire_kind_o    (wire_kind_o),
    .raw_value_o    (raw_value_o),
    .signed_value_o (signed_value_o),
    .payload_byte_o (payload_byte_o),
    .last_byte_o    (last_byte_o),
    .error_code_o   (error_code_o)
  );

  always #2 clk_i = ~clk_i;

  stream_beat_t  pending_beats[$];
  pbwd_result_t  expected_fields[$];
  pbwd_result_t  want;
  stream_beat_t  next_beat;
  int            fail_count = 0;
  bit            in_took = 1'b0;
  bit            out_took = 1'b0;
  int            in_gap = 0;
  int            out_wait = 0;
  bit            in_calm = 1'b0;
  bit            out_calm = 1'b0;

  // decoder shadow state
  dec_phase_e    dec_phase;
  logic [63:0]   dec_acc;
  logic [6:0]    dec_shift;
  logic [28:0]   dec_field;
  logic [2:0]    dec_wire;
  logic [3:0]    dec_fixed_left;
  logic [63:0]   dec_payload_left;

  function automatic void dec_clear();
    dec_acc   = 64'd0;
    dec_shift = 7'd0;
  endfunction

  function automatic void dec_reset();
    dec_phase        = DEC_TAG;
    dec_clear();
    dec_field        = 29'd0;
    dec_wire         = 3'd0;
    dec_fixed_left   = 4'd0;
    dec_payload_left = 64'd0;
  endfunction

  function automatic void queue_field(pbwd_kind_e k, logic [63:0] raw, logic [63:0] sval,
                                      logic [7:0] pbyte, logic last, pbwd_err_e err);
    pbwd_result_t r;
    r.kind         = k;
    r.field_number = dec_field;
    r.wire_kind    = dec_wire;
    r.raw_value    = raw;
    r.signed_value = sval;
    r.payload_byte = pbyte;
    r.last_byte    = last;
    r.error_code   = err;
    expected_fields.insert(expected_fields.size(), r);
  endfunction

  function automatic void dec_fail(pbwd_err_e err);
    queue_field(KIND_ERROR, 64'd0, 64'd0, 8'd0, 1'b0, err);
    dec_clear();
    dec_phase = DEC_HALT;
  endfunction

  function automatic varint_step_e varint_absorb(logic [7:0] b);
    if ((dec_acc & TOP7_MASK) != 64'd0) return VI_OVF;
    if (dec_shift < 7'd64) begin
      dec_acc   = dec_acc | ({57'd0, b[6:0]} << dec_shift);
      dec_shift = dec_shift + 7'd7;
    end
    return b[7] ? VI_MORE : VI_DONE;
  endfunction

  function automatic void predict_beat(logic [7:0] b, logic eos);
    varint_step_e st;
    logic [63:0]  v;
    logic [63:0]  sval;
    if (eos) begin
      if (dec_phase == DEC_HALT || (dec_phase == DEC_TAG && dec_shift == 7'd0)) begin
        dec_reset();
        return;
      end
      if (dec_phase == DEC_TAG) begin
        dec_field = 29'd0;
        dec_wire  = 3'd0;
      end
      queue_field(KIND_ERROR, 64'd0, 64'd0, 8'd0, 1'b0, ERR_TRUNCATED);
      dec_reset();
      return;
    end
    case (dec_phase)
      DEC_TAG: begin
        dec_field = 29'd0;
        dec_wire  = 3'd0;
        st = varint_absorb(b);
        if (st == VI_OVF) begin
          dec_fail(ERR_VARINT_OVF);
        end else if (st == VI_DONE) begin
          v = dec_acc;
          dec_clear();
          if (v > 64'hffff_ffff) begin
            dec_fail(ERR_TAG_OVF);
          end else begin
            dec_field = v[31:3];
            dec_wire  = v[2:0];
            case (dec_wire)
              WIRE_VARINT: dec_phase = DEC_VARINT;
              WIRE_FIXED64: begin
                dec_fixed_left = 4'd8;
                dec_phase      = DEC_FIXED;
              end
              WIRE_FIXED32: begin
                dec_fixed_left = 4'd4;
                dec_phase      = DEC_FIXED;
              end
              WIRE_LEN: dec_phase = DEC_LENGTH;
              default: dec_fail(ERR_BAD_WIRE);
            endcase
          end
        end
      end
      DEC_VARINT: begin
        st = varint_absorb(b);
        if (st == VI_OVF) begin
          dec_fail(ERR_VARINT_OVF);
        end else if (st == VI_DONE) begin
          v = dec_acc;
          queue_field(KIND_SCALAR, v, (v >> 1) ^ {64{v[0]}}, 8'd0, 1'b0, ERR_NONE);
          dec_clear();
          dec_phase = DEC_TAG;
        end
      end
      DEC_FIXED: begin
        if (dec_shift < 7'd64) begin
          dec_acc   = dec_acc | ({56'd0, b} << dec_shift);
          dec_shift = dec_shift + 7'd8;
        end
        if (dec_fixed_left > 4'd0) dec_fixed_left = dec_fixed_left - 4'd1;
        if (dec_fixed_left == 4'd0) begin
          v = dec_acc;
          if (dec_wire == WIRE_FIXED32) begin
            v    = {32'd0, v[31:0]};
            sval = {{32{v[31]}}, v[31:0]};
          end else begin
            sval = v;
          end
          queue_field(KIND_SCALAR, v, sval, 8'd0, 1'b0, ERR_NONE);
          dec_clear();
          dec_phase = DEC_TAG;
        end
      end
      DEC_LENGTH: begin
        st = varint_absorb(b);
        if (st == VI_OVF) begin
          dec_fail(ERR_VARINT_OVF);
        end else if (st == VI_DONE) begin
          dec_payload_left = dec_acc;
          queue_field(KIND_LENGTH, dec_payload_left, 64'd0, 8'd0, 1'b0, ERR_NONE);
          dec_clear();
          dec_phase = (dec_payload_left == 64'd0) ? DEC_TAG : DEC_PAYLOAD;
        end
      end
      DEC_PAYLOAD: begin
        if (dec_payload_left > 64'd0) dec_payload_left = dec_payload_left - 64'd1;
        queue_field(KIND_PAYLOAD, 64'd0, 64'd0, b, dec_payload_left == 64'd0, ERR_NONE);
        if (dec_payload_left == 64'd0) dec_phase = DEC_TAG;
      end
      default: begin
      end
    endcase
  endfunction

  // stimulus helpers
  function automatic void push_beat(logic [7:0] data, logic eos);
    stream_beat_t s;
    s.data = data;
    s.eos  = eos;
    pending_beats.insert(pending_beats.size(), s);
  endfunction

  function automatic void push_end();
    push_beat(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  // returns 1 when the encoding trips the overflow check and a resync end was added
  function automatic bit push_varint(logic [63:0] v, int pad);
    int          n;
    int          total;
    logic [63:0] rest;
    logic [7:0]  b;
    bit          ovf;
    n    = 1;
    rest = v >> 7;
    while (rest != 64'd0) begin
      n++;
      rest = rest >> 7;
    end
    total = n + pad;
    if (total > 10) total = 10;
    ovf  = (total == 10) && (v[62:57] != 6'd0);
    rest = v;
    for (int i = 0; i < total; i++) begin
      b    = {(i < total - 1), rest[6:0]};
      rest = rest >> 7;
      if (i == 9 && $urandom_range(0, 1) == 1) b[6:1] = 6'($urandom);
      push_beat(b, 1'b0);
    end
    if (ovf) push_end();
    return ovf;
  endfunction

  function automatic int pick_pad();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1: v = '1;
      2: v = 64'h8000_0000_0000_0000;
      3: v = {$urandom, $urandom};
      4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      5: v = 64'($urandom_range(0, 300));
      6: v = 64'h7fff_ffff_ffff_ffff;
      default: v = {32'd0, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [28:0] pick_field_number();
    case ($urandom_range(0, 4))
      0: return 29'd0;
      1: return '1;
      2: return 29'($urandom_range(1, 15));
      3: return 29'($urandom);
      default: return 29'($urandom_range(16, 2047));
    endcase
  endfunction

  function automatic logic [2:0] pick_good_wire();
    case ($urandom_range(0, 3))
      0: return WIRE_VARINT;
      1: return WIRE_FIXED64;
      2: return WIRE_LEN;
      default: return WIRE_FIXED32;
    endcase
  endfunction

  function automatic void push_field();
    logic [28:0] f;
    logic [2:0]  w;
    logic [63:0] v;
    int          len;
    f = pick_field_number();
    w = pick_good_wire();
    void'(push_varint({32'd0, f, w}, pick_pad()));
    case (w)
      WIRE_VARINT: void'(push_varint(pick_value(), pick_pad()));
      WIRE_FIXED64: begin
        v = pick_value();
        for (int i = 0; i < 8; i++) push_beat(v[8*i +: 8], 1'b0);
      end
      WIRE_FIXED32: begin
        v = pick_value();
        for (int i = 0; i < 4; i++) push_beat(v[8*i +: 8], 1'b0);
      end
      default: begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        if (!push_varint(64'(len), pick_pad())) begin
          for (int i = 0; i < len; i++) push_beat(8'($urandom_range(0, 255)), 1'b0);
        end
      end
    endcase
  endfunction

  function automatic void push_broken(int sel);
    logic [2:0] w;
    int         cnt;
    case (sel)
      0: begin
        // cut short inside a field
        void'(push_varint({32'd0, pick_field_number(), pick_good_wire()}, 0));
        cnt = $urandom_range(0, 3);
        for (int i = 0; i < cnt; i++) push_beat(8'($urandom_range(0, 255)) | 8'h80, 1'b0);
        push_end();
      end
      1: begin
        case ($urandom_range(0, 3))
          0: w = 3'd3;
          1: w = 3'd4;
          2: w = 3'd6;
          default: w = 3'd7;
        endcase
        void'(push_varint({32'd0, pick_field_number(), w}, 0));
        cnt = $urandom_range(0, 2);
        for (int i = 0; i < cnt; i++) push_beat(8'($urandom_range(0, 255)), 1'b0);
        push_end();
      end
      2: begin
        if ($urandom_range(0, 1) == 1) push_beat(8'h08, 1'b0);
        cnt = $urandom_range(10, 12);
        for (int i = 0; i < cnt; i++) push_beat(8'hff, 1'b0);
        push_end();
      end
      3: begin
        void'(push_varint({24'd0, 8'($urandom_range(1, 255)), $urandom}, 0));
        push_end();
      end
      4: begin
        // huge length header, then truncated payload
        void'(push_varint({32'd0, pick_field_number(), WIRE_LEN}, 0));
        if (!push_varint(pick_value() | 64'd64, 0)) begin
          cnt = $urandom_range(0, 3);
          for (int i = 0; i < cnt; i++) push_beat(8'($urandom_range(0, 255)), 1'b0);
          push_end();
        end
      end
      5: begin
        cnt = $urandom_range(1, 4);
        for (int i = 0; i < cnt; i++) push_beat(8'($urandom_range(0, 255)), 1'b0);
        push_end();
      end
      default: push_end();
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #2_000_000;
    $display("tb_protobuf_wire_field_decoder: FAIL");
    $finish;
  end

  initial begin
    int target;
    dec_reset();
    push_end();
    push_beat(8'h00, 1'b0); push_beat(8'h00, 1'b0);
    push_beat(8'h0d, 1'b0); push_beat(8'h00, 1'b0); push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b0); push_beat(8'h80, 1'b0);
    push_beat(8'h12, 1'b0); push_beat(8'h00, 1'b0);
    push_beat(8'h1a, 1'b0); push_beat(8'h01, 1'b0); push_beat(8'hff, 1'b0);
    push_beat(8'h0b, 1'b0); push_beat(8'h08, 1'b0); push_end();
    push_beat(8'h80, 1'b0); push_end();
    push_beat(8'h80, 1'b0); push_beat(8'h80, 1'b0); push_beat(8'h80, 1'b0);
    push_beat(8'h80, 1'b0); push_beat(8'h10, 1'b0); push_end();
    target = pending_beats.size() + 500;
    while (pending_beats.size() < target) begin
      if ($urandom_range(0, 19) < 13) push_field();
      else push_broken($urandom_range(0, 6));
    end
    while (pending_beats.size() != 0 || in_valid_i || expected_fields.size() != 0)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && expected_fields.size() == 0) begin
      $display("tb_protobuf_wire_field_decoder: PASS");
    end else begin
      $display("tb_protobuf_wire_field_decoder: FAIL");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_took) begin
        in_gap = in_calm ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
      end
      if (!in_valid_i || in_took) begin
        if (in_gap > 0 || pending_beats.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid_i <= 1'b0;
        end else begin
          next_beat = pending_beats.pop_front();
          data_byte_i  <= next_beat.data;
          stream_end_i <= next_beat.eos;
          in_valid_i   <= 1'b1;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) begin
        out_wait = out_calm ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    in_took  = rst_ni && in_valid_i && in_ready_o;
    out_took = rst_ni && out_valid_o && out_ready_i;
    if (in_took) predict_beat(data_byte_i, stream_end_i);
    if (out_took) begin
      if (expected_fields.size() == 0) begin
        $error("unexpected beat: kind %0d", kind_o);
        fail_count++;
      end else begin
        want = expected_fields.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind_o);
          fail_count++;
        end
        if (field_number_o !== want.field_number) begin
          $error("field_number: expected %0d, actual %0d", want.field_number, field_number_o);
          fail_count++;
        end
        if (wire_kind_o !== want.wire_kind) begin
          $error("wire_kind: expected %0d, actual %0d", want.wire_kind, wire_kind_o);
          fail_count++;
        end
        if (raw_value_o !== want.raw_value) begin
          $error("raw_value: expected %0h, actual %0h", want.raw_value, raw_value_o);
          fail_count++;
        end
        if (signed_value_o !== want.signed_value) begin
          $error("signed_value: expected %0d, actual %0d", want.signed_value, signed_value_o);
          fail_count++;
        end
        if (payload_byte_o !== want.payload_byte) begin
          $error("payload_byte: expected %0h, actual %0h", want.payload_byte, payload_byte_o);
          fail_count++;
        end
        if (last_byte_o !== want.last_byte) begin
          $error("last_byte: expected %0d, actual %0d", want.last_byte, last_byte_o);
          fail_count++;
        end
        if (error_code_o !== want.error_code) begin
          $error("error_code: expected %0d, actual %0d", want.error_code, error_code_o);
          fail_count++;
        end
      end
    end
  end

endmodule

/* protobuf_wire_field_decoder.f */
src/pbwd_pkg.sv
src/pbwd_core.sv
src/pbwd_out_buf.sv
src/protobuf_wire_field_decoder.sv
src/pbwd_checker.sv
tb/tb_protobuf_wire_field_decoder.sv
